FILE: hw/rtl/tlj_pkg.sv
// ----------------------------------------------------------------------------
// tlj_pkg: shared definitions for the text line justifier
// Sizes, register reset value and sequencer state encoding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlj_pkg;

    // line geometry
    localparam int MAX_LINE_WIDTH = 120;
    localparam int MAX_LINE_WORDS = 60;

    // field widths
    localparam int LEN_W   = 7;
    localparam int COUNT_W = 6;
    localparam int ADDR_W  = $clog2(MAX_LINE_WORDS);

    // spare width before division fits in one more bit than a length
    localparam int SPARE_W = LEN_W + 1;
    localparam int STEP_W  = $clog2(SPARE_W);

    localparam logic [LEN_W-1:0] LINE_WIDTH_RESET = LEN_W'(80);

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

endpackage

FILE: hw/rtl/tlj_ram.sv
// ----------------------------------------------------------------------------
// tlj_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/text_line_justifier_unit.sv
// ----------------------------------------------------------------------------
// text_line_justifier_unit: greedy fully justified line filling
// Buffers word lengths of the open line and emits one beat per word when the
// line closes, with the spaces that follow it.
// ----------------------------------------------------------------------------
// A word that fits on the open line is appended and the unit stays ready
// for the next word. A word that closes a line, or a final word, holds the
// input off while the line is emitted: a setup step, the shared restoring
// divider (spare width over gap count, only for lines of several words
// that fit), one beat per buffered word read from the line buffer at one
// word per cycle when the output is not stalled, and a wrap-up step. A
// final word that also closes a line emits both lines before the next word
// is taken. The width register is read for each fit test and when a line
// is set up, values above 120 act as 120.
`timescale 1ns / 1ps

module text_line_justifier_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: line_width
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    // input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [6:0] word_length, [7] zero
    input  logic        s_axis_tlast,   // final_word
    // placed words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [6:0] out_word_length, [13:7] spaces_after,
                                        // [15:14] zero
    output logic        m_axis_tuser,   // line_end
    output logic        m_axis_tlast    // run_last
);

    localparam int LEN_W   = tlj_pkg::LEN_W;
    localparam int COUNT_W = tlj_pkg::COUNT_W;
    localparam int ADDR_W  = tlj_pkg::ADDR_W;
    localparam int SPARE_W = tlj_pkg::SPARE_W;
    localparam int STEP_W  = tlj_pkg::STEP_W;

    // control registers
    tlj_pkg::t_state      r_state,      n_state;
    logic [LEN_W-1:0]     r_line_width, n_line_width;
    logic [COUNT_W-1:0]   r_count,      n_count;
    logic [LEN_W-1:0]     r_used,       n_used;
    logic                 r_old,        n_old;
    logic                 r_ovalid,     n_ovalid;

    // payload / datapath registers
    logic [LEN_W-1:0]     r_w,      n_w;
    logic                 r_fin,    n_fin;
    logic [COUNT_W-1:0]   r_n,      n_n;
    logic                 r_single, n_single;
    logic [SPARE_W-1:0]   r_quo,    n_quo;
    logic [COUNT_W-1:0]   r_rem,    n_rem;
    logic [STEP_W-1:0]    r_step,   n_step;
    logic [COUNT_W-1:0]   r_idx,    n_idx;
    logic [LEN_W-1:0]     r_olen,   n_olen;
    logic [LEN_W-1:0]     r_ospc,   n_ospc;
    logic                 r_oend,   n_oend;
    logic                 r_olast,  n_olast;

    // line buffer port
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [LEN_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [LEN_W-1:0]     ram_rdata;

    // datapath helpers
    logic [LEN_W-1:0]     w_eff;
    logic [LEN_W-1:0]     in_len;
    logic [SPARE_W:0]     fit_sum;
    logic                 close_line;
    logic [COUNT_W-1:0]   gaps;
    logic [SPARE_W-1:0]   spare;
    logic [LEN_W:0]       div_acc;
    logic [LEN_W+1:0]     div_diff;
    logic                 out_free;
    logic [COUNT_W-1:0]   idx_next;
    logic [SPARE_W-1:0]   gap_spaces;

    tlj_ram #(
        .WIDTH (LEN_W),
        .DEPTH (tlj_pkg::MAX_LINE_WORDS)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // effective width and close test
    assign w_eff = (r_line_width > LEN_W'(tlj_pkg::MAX_LINE_WIDTH))
                   ? LEN_W'(tlj_pkg::MAX_LINE_WIDTH) : r_line_width;
    assign in_len   = s_axis_tdata[LEN_W-1:0];
    assign fit_sum  = (SPARE_W+1)'(r_used) + (SPARE_W+1)'(in_len) + (SPARE_W+1)'(1);
    assign close_line = (r_count != '0) &&
                        ((fit_sum > (SPARE_W+1)'(w_eff)) ||
                         (r_count >= COUNT_W'(tlj_pkg::MAX_LINE_WORDS)));

    // used width equals chars plus gaps, so spare = width - used + gaps
    assign gaps  = r_count - COUNT_W'(1);
    assign spare = SPARE_W'(w_eff) - SPARE_W'(r_used) + SPARE_W'(gaps);

    // shared restoring divide step
    assign div_acc  = {(LEN_W-COUNT_W)'(0), r_rem, r_quo[SPARE_W-1]};
    assign div_diff = (LEN_W+2)'(div_acc) - (LEN_W+2)'(r_n - COUNT_W'(1));

    assign out_free   = !r_ovalid || m_axis_tready;
    assign idx_next   = r_idx + COUNT_W'(1);
    assign gap_spaces = r_quo + ((r_idx < r_rem) ? SPARE_W'(1) : SPARE_W'(0));

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_line_width = r_line_width;
        n_count      = r_count;
        n_used       = r_used;
        n_old        = r_old;
        n_ovalid     = r_ovalid && !m_axis_tready;
        n_w          = r_w;
        n_fin        = r_fin;
        n_n          = r_n;
        n_single     = r_single;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_step       = r_step;
        n_idx        = r_idx;
        n_olen       = r_olen;
        n_ospc       = r_ospc;
        n_oend       = r_oend;
        n_olast      = r_olast;
        ram_we       = 1'b0;
        ram_waddr    = r_count[ADDR_W-1:0];
        ram_wdata    = in_len;
        ram_re       = 1'b0;
        ram_raddr    = '0;

        if (i_cfg_wr_en) begin
            n_line_width = i_cfg_wr_data;
        end

        unique case (r_state)
            tlj_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_w   = in_len;
                    n_fin = s_axis_tlast;
                    if (close_line) begin
                        n_old   = 1'b1;
                        n_state = tlj_pkg::S_PREP;
                    end else begin
                        // append word to the open line
                        ram_we  = 1'b1;
                        n_count = r_count + COUNT_W'(1);
                        n_used  = (r_count == '0) ? in_len
                                  : LEN_W'(fit_sum);
                        n_old   = 1'b0;
                        if (s_axis_tlast) begin
                            n_state = tlj_pkg::S_PREP;
                        end
                    end
                end
            end

            tlj_pkg::S_PREP: begin
                // fetch first word, set up spacing for the line
                ram_re   = 1'b1;
                n_n      = r_count;
                n_idx    = '0;
                n_single = (r_count == COUNT_W'(1));
                n_rem    = '0;
                if (r_count == COUNT_W'(1)) begin
                    n_quo   = (w_eff > r_used) ? SPARE_W'(w_eff - r_used) : '0;
                    n_state = tlj_pkg::S_EMIT;
                end else if (w_eff < r_used) begin
                    n_quo   = SPARE_W'(1);
                    n_state = tlj_pkg::S_EMIT;
                end else begin
                    n_quo   = spare;
                    n_step  = STEP_W'(SPARE_W - 1);
                    n_state = tlj_pkg::S_DIV;
                end
            end

            tlj_pkg::S_DIV: begin
                // one quotient bit per cycle
                if (!div_diff[LEN_W+1]) begin
                    n_rem = div_diff[COUNT_W-1:0];
                    n_quo = {r_quo[SPARE_W-2:0], 1'b1};
                end else begin
                    n_rem = div_acc[COUNT_W-1:0];
                    n_quo = {r_quo[SPARE_W-2:0], 1'b0};
                end
                n_step = r_step - STEP_W'(1);
                if (r_step == '0) begin
                    n_state = tlj_pkg::S_EMIT;
                end
            end

            tlj_pkg::S_EMIT: begin
                if (r_idx != r_n) begin
                    if (out_free) begin
                        // load the next word beat, prefetch the one after
                        n_ovalid = 1'b1;
                        n_olen   = ram_rdata;
                        n_oend   = (idx_next == r_n);
                        n_olast  = (idx_next == r_n) && !(r_old && r_fin);
                        if (r_single) begin
                            n_ospc = r_quo[LEN_W-1:0];
                        end else if (idx_next != r_n) begin
                            n_ospc = gap_spaces[LEN_W-1:0];
                        end else begin
                            n_ospc = '0;
                        end
                        n_idx = idx_next;
                        if (idx_next != r_n) begin
                            ram_re    = 1'b1;
                            ram_raddr = idx_next[ADDR_W-1:0];
                        end
                    end
                end else begin
                    // line done: start the next one
                    n_count = '0;
                    n_used  = '0;
                    if (r_old) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = r_w;
                        n_count   = COUNT_W'(1);
                        n_used    = r_w;
                        n_old     = 1'b0;
                        n_state   = r_fin ? tlj_pkg::S_PREP : tlj_pkg::S_IDLE;
                    end else begin
                        n_state = tlj_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = tlj_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tlj_pkg::S_IDLE;
            r_line_width <= tlj_pkg::LINE_WIDTH_RESET;
            r_count      <= '0;
            r_used       <= '0;
            r_old        <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_line_width <= n_line_width;
            r_count      <= n_count;
            r_used       <= n_used;
            r_old        <= n_old;
            r_ovalid     <= n_ovalid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_fin    <= n_fin;
        r_n      <= n_n;
        r_single <= n_single;
        r_quo    <= n_quo;
        r_rem    <= n_rem;
        r_step   <= n_step;
        r_idx    <= n_idx;
        r_olen   <= n_olen;
        r_ospc   <= n_ospc;
        r_oend   <= n_oend;
        r_olast  <= n_olast;
    end

    // ports
    assign s_axis_tready = (r_state == tlj_pkg::S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {2'b00, r_ospc, r_olen};
    assign m_axis_tuser  = r_oend;
    assign m_axis_tlast  = r_olast;

endmodule

FILE: dv/tb_text_line_justifier_unit.sv
// ----------------------------------------------------------------------------
// tb_text_line_justifier_unit: self-checking bench for the line justifier
// Feeds word lengths through the input stream, fills lines in a predictor of
// its own and checks every placed word beat against it, over several line
// widths, with random gaps, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef logic [tlj_pkg::LEN_W-1:0] t_len;

// one placed word as it leaves the block
typedef struct packed {
    t_len len;
    t_len spaces;
    logic line_end;
    logic run_last;
} t_placed_word;

// greedy line filler and expected-word store
class justify_scoreboard;
    t_len           width_reg;
    t_len           line_buf [tlj_pkg::MAX_LINE_WORDS];
    int unsigned    n_buffered;
    int unsigned    used_chars;
    t_placed_word   expected_q [$];
    int unsigned    errors;
    int unsigned    words_in;
    int unsigned    beats_out;
    int unsigned    lines_out;

    function new();
        width_reg  = tlj_pkg::LINE_WIDTH_RESET;
        n_buffered = 0;
        used_chars = 0;
        errors     = 0;
        words_in   = 0;
        beats_out  = 0;
        lines_out  = 0;
    endfunction

    function void set_width(t_len value);
        width_reg = value;
    endfunction

    // widths above the maximum act as the maximum
    function int unsigned eff_width();
        return (width_reg > tlj_pkg::MAX_LINE_WIDTH) ? tlj_pkg::MAX_LINE_WIDTH : width_reg;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    // justify the buffered line into expected beats and empty the buffer
    function void close_line();
        int unsigned  width;
        int unsigned  chars;
        int unsigned  gaps;
        int unsigned  base;
        int unsigned  rem;
        int unsigned  sp;
        t_placed_word pw;
        width = eff_width();
        if (n_buffered == 0) return;
        pw.run_last = 1'b0;
        if (n_buffered == 1) begin
            // lone word pads right, oversized word gets nothing
            pw.len      = line_buf[0];
            pw.spaces   = (width > line_buf[0]) ? t_len'(width - line_buf[0]) : '0;
            pw.line_end = 1'b1;
            expected_q.insert(expected_q.size(), pw);
        end else begin
            gaps  = n_buffered - 1;
            chars = 0;
            for (int i = 0; i < n_buffered; i++) chars += line_buf[i];
            if (width >= chars + gaps) begin
                base = (width - chars) / gaps;
                rem  = (width - chars) % gaps;
            end else begin
                // no spare room: single spaces
                base = 1;
                rem  = 0;
            end
            for (int i = 0; i < n_buffered; i++) begin
                sp = 0;
                if (i < gaps) sp = base + ((i < rem) ? 1 : 0);
                pw.len      = line_buf[i];
                pw.spaces   = t_len'(sp);
                pw.line_end = (i == gaps);
                expected_q.insert(expected_q.size(), pw);
            end
        end
        n_buffered = 0;
        used_chars = 0;
    endfunction

    // accepted input beat
    function void note_word(t_len len, bit fin);
        int unsigned  before_n;
        before_n = expected_q.size();
        words_in++;
        // word that does not fit, or a full buffer, closes the open line
        if (n_buffered != 0 &&
            (used_chars + len + 1 > eff_width() ||
             n_buffered >= tlj_pkg::MAX_LINE_WORDS))
            close_line();
        if (n_buffered == 0) begin
            line_buf[0] = len;
            n_buffered  = 1;
            used_chars  = len;
        end else begin
            line_buf[n_buffered] = len;
            n_buffered++;
            used_chars += len + 1;
        end
        if (fin) close_line();
        // mark the last beat caused by this word
        if (expected_q.size() > before_n)
            expected_q[expected_q.size() - 1].run_last = 1'b1;
    endfunction

    // accepted output beat
    function void check_beat(t_placed_word got);
        t_placed_word want;
        beats_out++;
        if (got.line_end === 1'b1) lines_out++;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat len=%0d spaces=%0d line_end=%0b run_last=%0b",
                     $time, got.len, got.spaces, got.line_end, got.run_last);
            return;
        end
        want = expected_q.pop_front();
        if (got.len !== want.len) begin
            errors++;
            $display("%0t: word length expected %0d, got %0d", $time, want.len, got.len);
        end
        if (got.spaces !== want.spaces) begin
            errors++;
            $display("%0t: spaces expected %0d, got %0d", $time, want.spaces, got.spaces);
        end
        if (got.line_end !== want.line_end) begin
            errors++;
            $display("%0t: line_end expected %0b, got %0b", $time, want.line_end,
                     got.line_end);
        end
        if (got.run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b, got %0b", $time, want.run_last,
                     got.run_last);
        end
    endfunction
endclass

module tb_text_line_justifier_unit;

    localparam int    LEN_W         = tlj_pkg::LEN_W;
    localparam int    SETTLE_CYCLES = 80;
    localparam int    HOLD_CYCLES   = 300;
    localparam int    N_PHASES      = 9;
    localparam real   TIMEOUT_NS    = 2_000_000.0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [6:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [6:0] word_length, [7] zero
    logic        s_axis_tlast;   // final_word
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [6:0] out_word_length, [13:7] spaces_after, [15:14] zero
    logic        m_axis_tuser;   // line_end
    logic        m_axis_tlast;   // run_last

    justify_scoreboard sb;

    int unsigned tx_idle_pct  = 16;
    int unsigned rx_stall_pct = 16;
    bit          hold_req     = 1'b0;
    int unsigned n_widths     = 0;
    int          phase_width [N_PHASES] = '{1, 120, 120, 7, 127, 0, 0, 96, 80};

    text_line_justifier_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // register writes, accepted words and placed words, all seen at the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_wr_en) sb.set_width(i_cfg_wr_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_word(s_axis_tdata[LEN_W-1:0], s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_beat({m_axis_tdata[6:0], m_axis_tdata[13:7],
                               m_axis_tuser, m_axis_tlast});
        end
    end

    // output side: random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // offer one word, with an optional gap first; returns at its handshake edge
    task automatic send_word(input bit [6:0] len, input bit fin);
        int gap;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, len};
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // width write once all placed words are out and the block has settled
    task automatic write_width(input bit [6:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        n_widths++;
    endtask

    // stimulus
    initial begin
        int       n_items;
        int       r;
        bit [6:0] len;
        bit       fin;

        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset width: a three-word line, zero-length word, oversized word
        send_word(7'd10, 1'b0);
        send_word(7'd20, 1'b0);
        send_word(7'd30, 1'b1);
        send_word(7'd0, 1'b0);
        send_word(7'd7, 1'b1);
        send_word(7'd127, 1'b1);
        // lone-word lines, then a final word that also closes a line
        send_word(7'd40, 1'b0);
        send_word(7'd40, 1'b0);
        send_word(7'd64, 1'b1);
        // each length bit up to 32, uneven remainder over the gaps
        send_word(7'd1, 1'b0);
        send_word(7'd2, 1'b0);
        send_word(7'd4, 1'b0);
        send_word(7'd8, 1'b0);
        send_word(7'd16, 1'b0);
        send_word(7'd32, 1'b1);
        // zero width: every word alone, no padding
        write_width(7'd0);
        send_word(7'd3, 1'b0);
        send_word(7'd5, 1'b1);
        // width above the maximum, zero-length word padded to full width
        write_width(7'd127);
        send_word(7'd120, 1'b0);
        send_word(7'd0, 1'b1);
        // width shrunk under a buffered line
        send_word(7'd50, 1'b0);
        send_word(7'd50, 1'b0);
        write_width(7'd20);
        send_word(7'd1, 1'b1);

        // random phases, one width each; the open line carries over
        for (int p = 0; p < N_PHASES; p++) begin
            n_items = (p == 2) ? 80 : 36;
            write_width((p == 5) ? 7'($urandom_range(2, 119)) : 7'(phase_width[p]));
            tx_idle_pct  = (p == 5) ? 0 : 16;
            rx_stall_pct = (p == 5) ? 0 : 16;
            if (p == 3) hold_req = 1'b1;
            for (int k = 0; k < n_items; k++) begin
                r = $urandom_range(99);
                if (p == 2) begin
                    // tiny words on a wide line fill the word buffer
                    len = 7'($urandom_range(1));
                    fin = ($urandom_range(99) == 0);
                end else begin
                    if (r < 5)       len = 7'd0;
                    else if (r < 80) len = 7'($urandom_range(1, 12));
                    else if (r < 95) len = 7'($urandom_range(13, 60));
                    else             len = 7'($urandom_range(61, 127));
                    fin = ($urandom_range(11) == 0);
                end
                if (p == N_PHASES - 1 && k == n_items - 1) fin = 1'b1;
                send_word(len, fin);
            end
        end

        // drain
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d words, %0d placed words in %0d lines, %0d width writes",
                 sb.words_in, sb.beats_out, sb.lines_out, n_widths);
        $display("widths 0, 1, 7, 20, 80, 96, 120 and 127 plus one random, with a full buffer");
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
